// ----- hdl/gfc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// gfc_pkg
// Shared types, constants and helper functions for the global to Frenet
// converter: transaction structs, status and opcode codes, arctangent table.
// ============================================================================
package gfc_pkg;

  // Path storage
  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CFG_W      = 11;
  localparam int CNT_W      = CFG_W + 1;
  localparam logic [CFG_W-1:0] LOOK_AHEAD_RESET = CFG_W'(100);

  // APB register map: two registers at 4*i, 11 bits wide, read back zero-extended to 32 bits
  localparam int APB_AW = 3;
  localparam logic [0:0] REG_PATH_LENGTH = 1'b0;
  localparam logic [0:0] REG_LOOK_AHEAD  = 1'b1;

  // Arithmetic widths
  localparam int OPD_W  = 33;        // coordinate difference
  localparam int PROD_W = 2 * OPD_W; // one product
  localparam int ACC_W  = PROD_W + 2;// sum of two products
  localparam int SQ_W   = PROD_W + 1;// sum of two squares, unsigned
  localparam int ROOT_W = 36;

  // CORDIC
  localparam int CORDIC_STEPS = 17;
  localparam logic signed [31:0] HALF_PI_Q16 = 32'sd102944;

  // Opcodes
  localparam logic [0:0] OP_WRITE = 1'b0;
  localparam logic [0:0] OP_QUERY = 1'b1;

  // Result status
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_DEGEN = 2'd2;

  typedef struct packed {
    logic [0:0]         opcode;
    logic [IDX_W-1:0]   point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] heading;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] frenet_s;
    logic signed [31:0] frenet_d;
    logic signed [31:0] frenet_heading;
    logic [IDX_W-1:0]   closest_index;
    logic [1:0]         status;
  } out_item_t;

  // atan(2^-i) in Q16.16
  function automatic logic [15:0] atan_q16(input logic [4:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0:  v = 16'd51472;
      5'd1:  v = 16'd30386;
      5'd2:  v = 16'd16055;
      5'd3:  v = 16'd8150;
      5'd4:  v = 16'd4091;
      5'd5:  v = 16'd2047;
      5'd6:  v = 16'd1024;
      5'd7:  v = 16'd512;
      5'd8:  v = 16'd256;
      5'd9:  v = 16'd128;
      5'd10: v = 16'd64;
      5'd11: v = 16'd32;
      5'd12: v = 16'd16;
      5'd13: v = 16'd8;
      5'd14: v = 16'd4;
      5'd15: v = 16'd2;
      5'd16: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // Clamp a 35-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -35'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/gfc_store.sv -----
`timescale 1ns / 1ps
// ============================================================================
// gfc_store
// Waypoint memory: x and y arrays, one write port, one registered read port.
// ============================================================================
module gfc_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [gfc_pkg::IDX_W-1:0]  wr_addr,
  input  logic signed [31:0]         wr_x,
  input  logic signed [31:0]         wr_y,
  input  logic [gfc_pkg::IDX_W-1:0]  rd_addr,
  output logic signed [31:0]         rd_x,
  output logic signed [31:0]         rd_y
);
  import gfc_pkg::*;

  logic signed [31:0] mem_x [MAX_POINTS];
  logic signed [31:0] mem_y [MAX_POINTS];
  logic signed [31:0] rd_x_r, rd_y_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  assign rd_x = rd_x_r;
  assign rd_y = rd_y_r;

endmodule

// ----- hdl/gfc_sqrt.sv -----
`timescale 1ns / 1ps
// ============================================================================
// gfc_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ============================================================================
module gfc_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [gfc_pkg::SQ_W-1:0]    radicand,
  output logic                        done,
  output logic [gfc_pkg::ROOT_W-1:0]  root
);
  import gfc_pkg::*;

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 4;
  localparam int SC_W  = $clog2(ROOT_W);

  logic              busy_r, done_r;
  logic [SC_W-1:0]   cnt_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W-1:0]  rem_sh, trial;
  logic              fits;

  // Bring down two radicand bits, try root*4+1
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= RAD_W'(radicand);
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= rad_r << 2;
        rem_r  <= fits ? rem_sh - trial : rem_sh;
        root_r <= {root_r[ROOT_W-2:0], fits};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == SC_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- hdl/gfc_div.sv -----
`timescale 1ns / 1ps
// ============================================================================
// gfc_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero and saturating the quotient to 32 bits.
// ============================================================================
module gfc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [gfc_pkg::ACC_W-1:0]  numer,
  input  logic [gfc_pkg::ROOT_W-1:0]        denom,
  output logic                              done,
  output logic signed [31:0]                quot
);
  import gfc_pkg::*;

  localparam int DC_W = $clog2(ACC_W);

  logic              busy_r, done_r, neg_r;
  logic [DC_W-1:0]   cnt_r;
  logic [ACC_W-1:0]  mag_r, q_r;
  logic [ROOT_W-1:0] rem_r, den_r;
  logic [ROOT_W:0]   rem_sh, diff;
  logic              fits, pos_ovf, neg_ovf;

  assign rem_sh = {rem_r, mag_r[ACC_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= numer[ACC_W-1];
        mag_r  <= numer[ACC_W-1] ? ACC_W'(-numer) : ACC_W'(numer);
        den_r  <= denom;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        mag_r <= mag_r << 1;
        rem_r <= fits ? diff[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
        q_r   <= {q_r[ACC_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DC_W'(ACC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Apply sign and clamp
  assign pos_ovf = |q_r[ACC_W-1:31];
  assign neg_ovf = (|q_r[ACC_W-1:32]) || (q_r[31:0] > 32'h8000_0000);

  always_comb begin
    if (neg_r) begin
      quot = neg_ovf ? 32'sh8000_0000 : -$signed(q_r[31:0]);
    end else begin
      quot = pos_ovf ? 32'sh7FFF_FFFF : $signed(q_r[31:0]);
    end
  end

  assign done = done_r;

endmodule

// ----- hdl/gfc_atan.sv -----
`timescale 1ns / 1ps
// ============================================================================
// gfc_atan
// Vectoring-mode CORDIC atan2: normalizes the vector one doubling per cycle,
// folds the left half plane, then runs one CORDIC step per cycle.
// ============================================================================
module gfc_atan (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [gfc_pkg::OPD_W-1:0]  y_in,
  input  logic signed [gfc_pkg::OPD_W-1:0]  x_in,
  output logic                              done,
  output logic signed [31:0]                angle
);
  import gfc_pkg::*;

  localparam int CW         = 46;
  localparam int NORM_SHIFT = 40;
  localparam logic signed [CW-1:0] LIM = CW'(64'd1 << NORM_SHIFT);

  typedef enum logic [1:0] {A_IDLE, A_NORM, A_ITER} atan_state_t;

  atan_state_t        state_r;
  logic               done_r;
  logic signed [CW-1:0] x_r, y_r, xs, ys;
  logic signed [31:0] z_r, at;
  logic [4:0]         k_r;

  function automatic logic below_lim(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] m;
    m = v[CW-1] ? -v : v;
    return m < LIM;
  endfunction

  assign xs = x_r >>> k_r;
  assign ys = y_r >>> k_r;
  assign at = $signed({16'd0, atan_q16(k_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        A_IDLE: begin
          if (start) begin
            x_r     <= {{(CW-OPD_W){x_in[OPD_W-1]}}, x_in};
            y_r     <= {{(CW-OPD_W){y_in[OPD_W-1]}}, y_in};
            state_r <= A_NORM;
          end
        end
        // Double until one component reaches 2^40, then fold quadrants
        A_NORM: begin
          if (below_lim(x_r) && below_lim(y_r)) begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
          end else begin
            k_r <= '0;
            state_r <= A_ITER;
            if (x_r[CW-1]) begin
              if (!y_r[CW-1]) begin
                x_r <= y_r;
                y_r <= -x_r;
                z_r <= HALF_PI_Q16;
              end else begin
                x_r <= -y_r;
                y_r <= x_r;
                z_r <= -HALF_PI_Q16;
              end
            end else begin
              z_r <= '0;
            end
          end
        end
        // One micro-rotation per cycle
        A_ITER: begin
          if (!y_r[CW-1]) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + at;
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - at;
          end
          k_r <= k_r + 1'b1;
          if (k_r == 5'(CORDIC_STEPS - 1)) begin
            state_r <= A_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign angle = z_r;

endmodule

// ----- hdl/global_to_frenet_converter.sv -----
`timescale 1ns / 1ps
// ============================================================================
// global_to_frenet_converter
// Projects a vehicle pose onto a stored waypoint path, returning arc length,
// lateral offset and relative heading in Q16.16.
// ============================================================================
//  Channel  Direction  Handshake            Carries
//  in_      input      in_valid/in_ready    waypoint write or pose query
//  out_     output     out_valid/out_ready  one result per pose query
//  APB      config     psel/penable/pready  path_length @0x0, look_ahead @0x4
//
//  Pose query, W points searched and k segments walked, runs through the
//  shared multiplier, the bit-serial square root, divider and CORDIC.
//  One transaction is worked at a time.
//  A finished result sits in the output register; the next transaction is
//  taken meanwhile, and a later result waits until the first is taken.
//  Reset is synchronous; the waypoint memory is not cleared.
// ============================================================================
module global_to_frenet_converter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gfc_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gfc_pkg::out_item_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gfc_pkg::APB_AW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import gfc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_WAIT, ST_DOT1, ST_DOT2, ST_DOT3,
    ST_SRCH_RD, ST_SRCH_CMP,
    ST_BR_START, ST_BR_N_RD, ST_BR_NX_RD, ST_BR_NX_DONE, ST_BR_PV_DONE,
    ST_SEG_B_RD, ST_SEG_F_RD, ST_LEN_SQ, ST_LEN_WAIT, ST_D_DIV, ST_D_WAIT,
    ST_RUN_FIRST, ST_RUN_RD, ST_RUN_SQ, ST_RUN_WAIT,
    ST_S_START, ST_S_RD, ST_S_DIV, ST_S_WAIT,
    ST_HD_START, ST_HD_WAIT, ST_DONE
  } state_t;

  state_t state_r, dret_r, wret_r;

  // Configuration
  logic [CFG_W-1:0] path_length_r, look_ahead_r;

  // Persistent tracking state
  logic [IDX_W-1:0] last_nearest_r;
  logic [31:0]      running_length_r;

  // Query working registers
  logic [IDX_W-1:0]        addr_r, i_r, nearest_r, f_r, closest_r;
  logic [CFG_W-1:0]        n_r;
  logic [CNT_W-1:0]        end_r;
  logic signed [31:0]      px_r, py_r, yaw_r, xb_r, yb_r;
  logic signed [OPD_W-1:0] ex_r, ey_r, seg_a_r, seg_b_r;
  logic signed [OPD_W-1:0] mop_a_r, mop_b_r, op_a2_r, op_b2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r, to_next_r;
  logic [SQ_W-1:0]         best_r;
  logic [ROOT_W-1:0]       len_r;
  logic [31:0]             run_r;
  logic signed [31:0]      s_r, d_r, hd_r;
  logic [1:0]              status_r;
  logic                    sq_start_r, div_start_r, at_start_r;
  logic signed [ACC_W-1:0] div_num_r;
  logic [ROOT_W-1:0]       div_den_r;

  // Output register
  logic      out_valid_r;
  out_item_t out_data_r;

  // Memory and arithmetic units
  logic                    wr_en;
  logic signed [31:0]      rd_x, rd_y;
  logic                    sq_done, div_done, at_done;
  logic [ROOT_W-1:0]       sq_root;
  logic signed [31:0]      div_q, at_z;

  // Combinational helpers
  logic signed [OPD_W-1:0] dpx, dpy, dxs, dys, pxb, pyb, seg_a_c, neg_a;
  logic [CFG_W-1:0]        n_c;
  logic [CNT_W-1:0]        sum_c, end_c;
  logic [SQ_W-1:0]         dist_c;
  logic [ROOT_W:0]         run_sum;
  logic [IDX_W-1:0]        f_c;

  function automatic logic signed [OPD_W-1:0] sub33(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

  assign dpx     = sub33(px_r, rd_x);
  assign dpy     = sub33(py_r, rd_y);
  assign dxs     = sub33(rd_x, xb_r);
  assign dys     = sub33(rd_y, yb_r);
  assign pxb     = sub33(px_r, xb_r);
  assign pyb     = sub33(py_r, yb_r);
  assign seg_a_c = sub33(yb_r, rd_y);
  assign neg_a   = -seg_a_r;
  assign dist_c  = acc_r[SQ_W-1:0];
  assign run_sum = (ROOT_W+1)'(run_r) + (ROOT_W+1)'(sq_root);
  assign f_c     = (to_next_r < acc_r) ? nearest_r : nearest_r + 1'b1;

  // Search window bounds
  assign n_c   = (path_length_r > CFG_W'(MAX_POINTS)) ? CFG_W'(MAX_POINTS) : path_length_r;
  assign sum_c = CNT_W'(last_nearest_r) + CNT_W'(look_ahead_r);
  assign end_c = (sum_c > CNT_W'(n_c)) ? CNT_W'(n_c) : sum_c;

  // Handshakes
  assign in_ready  = (state_r == ST_IDLE);
  assign wr_en     = in_valid && in_ready && (in_data.opcode == OP_WRITE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;

  // APB register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_length_r <= '0;
      look_ahead_r  <= LOOK_AHEAD_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_PATH_LENGTH: path_length_r <= pwdata[CFG_W-1:0];
        REG_LOOK_AHEAD:  look_ahead_r  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PATH_LENGTH: prdata = 32'(path_length_r);
      REG_LOOK_AHEAD:  prdata = 32'(look_ahead_r);
      default:         prdata = '0;
    endcase
  end

  gfc_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_data.point_index),
    .wr_x    (in_data.coord_x),
    .wr_y    (in_data.coord_y),
    .rd_addr (addr_r),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  gfc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start_r),
    .radicand (dist_c),
    .done     (sq_done),
    .root     (sq_root)
  );

  gfc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .numer (div_num_r),
    .denom (div_den_r),
    .done  (div_done),
    .quot  (div_q)
  );

  gfc_atan u_atan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (at_start_r),
    .y_in  (neg_a),
    .x_in  (seg_b_r),
    .done  (at_done),
    .angle (at_z)
  );

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    prod_r <= mop_a_r * mop_b_r;
  end

  // Query sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      out_valid_r      <= 1'b0;
      last_nearest_r   <= '0;
      running_length_r <= '0;
      sq_start_r       <= 1'b0;
      div_start_r      <= 1'b0;
      at_start_r       <= 1'b0;
    end else begin
      sq_start_r  <= 1'b0;
      div_start_r <= 1'b0;
      at_start_r  <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        // Take a write or a query
        ST_IDLE: begin
          if (in_valid && in_data.opcode == OP_QUERY) begin
            px_r      <= in_data.coord_x;
            py_r      <= in_data.coord_y;
            yaw_r     <= in_data.heading;
            n_r       <= n_c;
            end_r     <= end_c;
            closest_r <= last_nearest_r;
            status_r  <= STAT_OK;
            s_r       <= '0;
            d_r       <= '0;
            hd_r      <= '0;
            if (n_c < CFG_W'(2)) begin
              status_r <= STAT_DEGEN;
              state_r  <= ST_DONE;
            end else if (CNT_W'(last_nearest_r) >= end_c) begin
              status_r <= STAT_EMPTY;
              state_r  <= ST_DONE;
            end else begin
              i_r     <= last_nearest_r;
              addr_r  <= last_nearest_r;
              wret_r  <= ST_SRCH_RD;
              state_r <= ST_WAIT;
            end
          end
        end

        // Memory read latency
        ST_WAIT: state_r <= wret_r;

        // Two-term dot product through the shared multiplier
        ST_DOT1: begin
          mop_a_r <= op_a2_r;
          mop_b_r <= op_b2_r;
          state_r <= ST_DOT2;
        end
        ST_DOT2: begin
          acc_r   <= {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
          state_r <= ST_DOT3;
        end
        ST_DOT3: begin
          acc_r   <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
          state_r <= dret_r;
        end

        // Nearest waypoint search; next point is prefetched
        ST_SRCH_RD: begin
          mop_a_r <= dpx;
          mop_b_r <= dpx;
          op_a2_r <= dpy;
          op_b2_r <= dpy;
          addr_r  <= i_r + 1'b1;
          dret_r  <= ST_SRCH_CMP;
          state_r <= ST_DOT1;
        end
        ST_SRCH_CMP: begin
          // later equal distance wins
          if (i_r == last_nearest_r || dist_c <= best_r) begin
            best_r    <= dist_c;
            nearest_r <= i_r;
          end
          if (CNT_W'(i_r) + 1'b1 < end_r) begin
            i_r     <= i_r + 1'b1;
            state_r <= ST_SRCH_RD;
          end else begin
            state_r <= ST_BR_START;
          end
        end

        // Pick the bracketing segment
        ST_BR_START: begin
          closest_r <= nearest_r;
          wret_r    <= ST_SEG_B_RD;
          state_r   <= ST_WAIT;
          if (nearest_r == '0) begin
            addr_r <= '0;
            f_r    <= IDX_W'(1);
          end else if (CFG_W'(nearest_r) == n_r - 1'b1) begin
            addr_r <= IDX_W'(n_r - CFG_W'(2));
            f_r    <= IDX_W'(n_r - 1'b1);
          end else begin
            addr_r <= nearest_r;
            wret_r <= ST_BR_N_RD;
          end
        end
        ST_BR_N_RD: begin
          ex_r    <= dpx;
          ey_r    <= dpy;
          xb_r    <= rd_x;
          yb_r    <= rd_y;
          addr_r  <= nearest_r + 1'b1;
          wret_r  <= ST_BR_NX_RD;
          state_r <= ST_WAIT;
        end
        ST_BR_NX_RD: begin
          mop_a_r <= ex_r;
          mop_b_r <= dxs;
          op_a2_r <= ey_r;
          op_b2_r <= dys;
          addr_r  <= nearest_r - 1'b1;
          dret_r  <= ST_BR_NX_DONE;
          state_r <= ST_DOT1;
        end
        ST_BR_NX_DONE: begin
          to_next_r <= acc_r;
          mop_a_r   <= ex_r;
          mop_b_r   <= dxs;
          op_a2_r   <= ey_r;
          op_b2_r   <= dys;
          dret_r    <= ST_BR_PV_DONE;
          state_r   <= ST_DOT1;
        end
        ST_BR_PV_DONE: begin
          f_r     <= f_c;
          addr_r  <= f_c - 1'b1;
          wret_r  <= ST_SEG_B_RD;
          state_r <= ST_WAIT;
        end

        // Segment endpoints and length
        ST_SEG_B_RD: begin
          xb_r    <= rd_x;
          yb_r    <= rd_y;
          addr_r  <= f_r;
          wret_r  <= ST_SEG_F_RD;
          state_r <= ST_WAIT;
        end
        ST_SEG_F_RD: begin
          if (seg_a_c == '0 && dxs == '0) begin
            status_r <= STAT_DEGEN;
            state_r  <= ST_DONE;
          end else begin
            seg_a_r <= seg_a_c;
            seg_b_r <= dxs;
            mop_a_r <= seg_a_c;
            mop_b_r <= seg_a_c;
            op_a2_r <= dxs;
            op_b2_r <= dxs;
            dret_r  <= ST_LEN_SQ;
            state_r <= ST_DOT1;
          end
        end
        ST_LEN_SQ: begin
          sq_start_r <= 1'b1;
          state_r    <= ST_LEN_WAIT;
        end
        ST_LEN_WAIT: begin
          if (sq_done) begin
            len_r   <= sq_root;
            mop_a_r <= seg_a_r;
            mop_b_r <= pxb;
            op_a2_r <= seg_b_r;
            op_b2_r <= pyb;
            dret_r  <= ST_D_DIV;
            state_r <= ST_DOT1;
          end
        end

        // Lateral offset
        ST_D_DIV: begin
          div_num_r   <= acc_r;
          div_den_r   <= len_r;
          div_start_r <= 1'b1;
          state_r     <= ST_D_WAIT;
        end
        ST_D_WAIT: begin
          if (div_done) begin
            d_r   <= div_q;
            run_r <= running_length_r;
            if (nearest_r == '0) begin
              run_r   <= '0;
              state_r <= ST_S_START;
            end else if (nearest_r == last_nearest_r) begin
              state_r <= ST_S_START;
            end else begin
              i_r     <= last_nearest_r;
              addr_r  <= last_nearest_r;
              wret_r  <= ST_RUN_FIRST;
              state_r <= ST_WAIT;
            end
          end
        end

        // Accumulate segment lengths up to the new nearest point
        ST_RUN_FIRST: begin
          xb_r    <= rd_x;
          yb_r    <= rd_y;
          addr_r  <= i_r + 1'b1;
          wret_r  <= ST_RUN_RD;
          state_r <= ST_WAIT;
        end
        ST_RUN_RD: begin
          mop_a_r <= dxs;
          mop_b_r <= dxs;
          op_a2_r <= dys;
          op_b2_r <= dys;
          xb_r    <= rd_x;
          yb_r    <= rd_y;
          dret_r  <= ST_RUN_SQ;
          state_r <= ST_DOT1;
        end
        ST_RUN_SQ: begin
          sq_start_r <= 1'b1;
          state_r    <= ST_RUN_WAIT;
        end
        ST_RUN_WAIT: begin
          if (sq_done) begin
            run_r <= (run_sum > (ROOT_W+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                           : run_sum[31:0];
            i_r   <= i_r + 1'b1;
            if (i_r + 1'b1 < nearest_r) begin
              addr_r  <= i_r + IDX_W'(2);
              wret_r  <= ST_RUN_RD;
              state_r <= ST_WAIT;
            end else begin
              state_r <= ST_S_START;
            end
          end
        end

        // Arc length: running length plus projection on the segment
        ST_S_START: begin
          addr_r  <= nearest_r;
          wret_r  <= ST_S_RD;
          state_r <= ST_WAIT;
        end
        ST_S_RD: begin
          mop_a_r <= dpx;
          mop_b_r <= seg_b_r;
          op_a2_r <= dpy;
          op_b2_r <= neg_a;
          dret_r  <= ST_S_DIV;
          state_r <= ST_DOT1;
        end
        ST_S_DIV: begin
          div_num_r   <= acc_r;
          div_den_r   <= len_r;
          div_start_r <= 1'b1;
          state_r     <= ST_S_WAIT;
        end
        ST_S_WAIT: begin
          if (div_done) begin
            s_r     <= sat32($signed({3'b000, run_r}) + 35'(div_q));
            state_r <= ST_HD_START;
          end
        end

        // Relative heading, then commit tracking state
        ST_HD_START: begin
          at_start_r <= 1'b1;
          state_r    <= ST_HD_WAIT;
        end
        ST_HD_WAIT: begin
          if (at_done) begin
            hd_r             <= sat32(35'(yaw_r) - 35'(at_z));
            last_nearest_r   <= nearest_r;
            running_length_r <= run_r;
            state_r          <= ST_DONE;
          end
        end

        // Hand the result to the output register
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r                <= 1'b1;
            out_data_r.frenet_s        <= s_r;
            out_data_r.frenet_d        <= d_r;
            out_data_r.frenet_heading  <= hd_r;
            out_data_r.closest_index   <= closest_r;
            out_data_r.status          <= status_r;
            state_r                    <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // Running length is clamped and never negative
  a_run_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !running_length_r[31])
    else $error("running length went negative");

  // Error results carry zero s, d and heading
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != STAT_OK |->
      out_data_r.frenet_s == '0 && out_data_r.frenet_d == '0 &&
      out_data_r.frenet_heading == '0)
    else $error("error result with nonzero payload");

  // Tracking index moves only on a successful conversion
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    last_nearest_r != $past(last_nearest_r) |-> $past(state_r) == ST_HD_WAIT)
    else $error("last nearest index changed outside commit");

  // Search never runs past the window end
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SRCH_CMP |-> CNT_W'(i_r) < end_r)
    else $error("search index beyond window");
`endif

endmodule
